/* rtl/sslu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sslu_pkg;

    // literal position
    typedef enum logic [1:0] {
        PH_START   = 2'd0,
        PH_AFTER_N = 2'd1,
        PH_BODY    = 2'd2
    } phase_t;

    // one output result
    typedef struct packed {
        logic [7:0] char_out;
        logic       char_valid;
        logic       end_of_text;
    } result_t;

    // results produced by one input transaction
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } push_t;

    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_UPPER_N   = 8'h4E;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_B   = 8'h62;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_SUB       = 8'h1A;

    localparam int unsigned REG_ESCAPES_DISABLED = 0;

    function automatic logic is_quote(input logic [7:0] c);
        return (c == CH_SQUOTE) || (c == CH_DQUOTE);
    endfunction

    // bit 8 flags a known escape, bits 7:0 the decoded byte
    function automatic logic [8:0] decode_escape(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            CH_SQUOTE, CH_DQUOTE, CH_BACKSLASH: r = {1'b1, c};
            CH_LOWER_B: r = {1'b1, CH_BS};
            CH_LOWER_N: r = {1'b1, CH_LF};
            CH_LOWER_R: r = {1'b1, CH_CR};
            CH_LOWER_T: r = {1'b1, CH_TAB};
            CH_ZERO:    r = {1'b1, CH_NUL};
            CH_UPPER_Z: r = {1'b1, CH_SUB};
            default:    r = {1'b0, c};
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/sslu_if.sv */
`timescale 1ns / 1ps
`default_nettype none

// input byte channel
interface sslu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       last_in;

    modport source (output valid, output char_in, output last_in, input ready);
    modport sink   (input valid, input char_in, input last_in, output ready);
endinterface

// decoded output channel
interface sslu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       char_valid;
    logic       end_of_text;

    modport source (output valid, output char_out, output char_valid,
                    output end_of_text, input ready);
    modport sink   (input valid, input char_out, input char_valid,
                    input end_of_text, output ready);
endinterface

`default_nettype wire

/* rtl/sslu_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none

module sslu_cfg
    import sslu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic             escapes_disabled
);

    logic esc_dis_reg;
    logic esc_dis_next;
    logic wr_en;

    // single register, any offset in its word selects it
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        esc_dis_next = esc_dis_reg;
        if (wr_en && (paddr[1:0] == 2'd0 || paddr[1:0] != 2'd0))
        begin
            esc_dis_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_dis_reg <= 1'b0;
        end
        else
        begin
            esc_dis_reg <= esc_dis_next;
        end
    end

    assign prdata           = {31'd0, esc_dis_reg};
    assign escapes_disabled = esc_dis_reg;

endmodule

`default_nettype wire

/* rtl/sslu_core.sv */
`timescale 1ns / 1ps
`default_nettype none

module sslu_core
    import sslu_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    sslu_in_if.sink    in_ch,
    input  wire logic  escapes_disabled,
    input  wire logic  room,
    output push_t      push
);

    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_last_reg;
    logic       take;

    phase_t     phase_reg, phase_next;
    logic       quoted_reg, quoted_next;
    logic [7:0] held_reg, held_next;
    logic       hv_reg, hv_next;

    // input register, refilled when its content moves on
    assign take         = in_valid_reg && room;
    assign in_ch.ready  = !in_valid_reg || room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.valid && in_ch.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_char_reg <= in_ch.char_in;
            in_last_reg <= in_ch.last_in;
        end
    end

    // decode one byte against the lookahead byte
    always_comb
    begin
        logic [7:0] c;
        logic [8:0] esc;
        logic       body;
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
        c    = in_char_reg;
        esc  = decode_escape(c);
        body = 1'b1;
        n    = 2'd0;
        r0   = '0;
        r1   = '0;
        phase_next  = phase_reg;
        quoted_next = quoted_reg;
        held_next   = held_reg;
        hv_next     = hv_reg;

        case (phase_reg)
            PH_START:
            begin
                body = 1'b0;
                if (in_last_reg)
                begin
                    n  = 2'd1;
                    r0 = '{char_out: c, char_valid: 1'b1, end_of_text: 1'b1};
                    phase_next = PH_START;
                    quoted_next = 1'b0;
                    held_next   = 8'd0;
                    hv_next     = 1'b0;
                end
                else if (is_quote(c))
                begin
                    quoted_next = 1'b1;
                    phase_next  = PH_BODY;
                    hv_next     = 1'b0;
                end
                else
                begin
                    held_next  = c;
                    hv_next    = 1'b1;
                    phase_next = (c == CH_UPPER_N || c == CH_LOWER_N) ? PH_AFTER_N : PH_BODY;
                end
            end
            PH_AFTER_N:
            begin
                phase_next = PH_BODY;
                if (is_quote(c) && !in_last_reg)
                begin
                    body        = 1'b0;
                    quoted_next = 1'b1;
                    hv_next     = 1'b0;
                    held_next   = 8'd0;
                end
            end
            default:
            begin
                body = 1'b1;
            end
        endcase

        if (body)
        begin
            if (quoted_reg && in_last_reg)
            begin
                n  = 2'd1;
                r0 = '{char_out: hv_reg ? held_reg : 8'd0, char_valid: hv_reg,
                       end_of_text: 1'b1};
                phase_next  = PH_START;
                quoted_next = 1'b0;
                held_next   = 8'd0;
                hv_next     = 1'b0;
            end
            else
            begin
                if (hv_reg)
                begin
                    n = 2'd1;
                    if (!escapes_disabled && held_reg == CH_BACKSLASH && esc[8])
                    begin
                        r0      = '{char_out: esc[7:0], char_valid: 1'b1, end_of_text: 1'b0};
                        hv_next = 1'b0;
                    end
                    else if (is_quote(held_reg) && c == held_reg)
                    begin
                        r0      = '{char_out: held_reg, char_valid: 1'b1, end_of_text: 1'b0};
                        hv_next = 1'b0;
                    end
                    else
                    begin
                        r0        = '{char_out: held_reg, char_valid: 1'b1, end_of_text: 1'b0};
                        held_next = c;
                    end
                end
                else
                begin
                    held_next = c;
                    hv_next   = 1'b1;
                end

                // flush the lookahead and close the literal
                if (in_last_reg)
                begin
                    if (hv_next)
                    begin
                        if (n == 2'd0)
                        begin
                            r0 = '{char_out: held_next, char_valid: 1'b1,
                                   end_of_text: 1'b1};
                        end
                        else
                        begin
                            r1 = '{char_out: held_next, char_valid: 1'b1,
                                   end_of_text: 1'b1};
                        end
                        n = n + 2'd1;
                    end
                    else
                    begin
                        r0.end_of_text = 1'b1;
                    end
                    phase_next  = PH_START;
                    quoted_next = 1'b0;
                    held_next   = 8'd0;
                    hv_next     = 1'b0;
                end
            end
        end

        push.count = take ? n : 2'd0;
        push.res0  = r0;
        push.res1  = r1;
    end

    // literal state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            quoted_reg <= 1'b0;
            held_reg   <= 8'd0;
            hv_reg     <= 1'b0;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            quoted_reg <= quoted_next;
            held_reg   <= held_next;
            hv_reg     <= hv_next;
        end
    end

    // a closing byte always yields a result and returns to start
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && in_last_reg) |-> (push.count != 2'd0))
        else $error("last byte produced no result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (take && in_last_reg) |=> (phase_reg == PH_START && !hv_reg && !quoted_reg))
        else $error("state not cleared after last byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        quoted_reg |-> (phase_reg != PH_AFTER_N))
        else $error("quoted mode while awaiting quote after N");

endmodule

`default_nettype wire

/* rtl/sslu_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module sslu_fifo
    import sslu_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire push_t  push,
    output logic        room,
    sslu_out_if.source  out_ch
);

    localparam int unsigned DEPTH = 4;

    result_t    mem [DEPTH];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       pop;

    assign pop  = out_ch.valid && out_ch.ready;
    assign room = (count_reg <= 3'd2);

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push.count;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push.count} - {2'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // result storage
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.res0;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_reg + 2'd1] <= push.res1;
        end
    end

    assign out_ch.valid       = (count_reg != 3'd0);
    assign out_ch.char_out    = mem[rd_ptr_reg].char_out;
    assign out_ch.char_valid  = mem[rd_ptr_reg].char_valid;
    assign out_ch.end_of_text = mem[rd_ptr_reg].end_of_text;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'd4)
        else $error("result queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> (count_reg <= 3'd2))
        else $error("push without room");

    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[1:0])
        else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire

/* rtl/sql_string_literal_unescaper_top.sv */
// order: a byte is registered at acceptance and its results are written into the output
//   queue when the byte is taken, which waits until the queue has room
// throughput: one byte per cycle while there is room; two results need two output pops
// the lookahead byte holds a result back until the next byte (or the last) arrives
// reset: asynchronous active low, clears literal state, queue and escapes_disabled
`timescale 1ns / 1ps
`default_nettype none

module sql_string_literal_unescaper_top
    import sslu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    sslu_in_if.sink          in_ch,
    sslu_out_if.source       out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic  escapes_disabled;
    logic  room;
    push_t push;

    // configuration register
    sslu_cfg u_cfg (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .escapes_disabled (escapes_disabled)
    );

    // byte decoder
    sslu_core u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_ch            (in_ch),
        .escapes_disabled (escapes_disabled),
        .room             (room),
        .push             (push)
    );

    // result queue
    sslu_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .room   (room),
        .out_ch (out_ch)
    );

endmodule

`default_nettype wire
